FILE: sv/nass_pkg.sv
// Shared types and constants for the n-ary sorted search block.
`default_nettype none

package nass_pkg;

  localparam int WORD_W = 32;
  localparam int POS_W  = 10;
  localparam int CFG_W  = 3;

  // Item kinds; kind code 3 means nothing and is dropped
  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_SEARCH = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  // Outcome of one probe compare
  typedef enum logic [1:0] {
    CMP_LESS    = 2'd0,
    CMP_GREATER = 2'd1,
    CMP_EQUAL   = 2'd2
  } cmp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_DIV,
    ST_ADDR,
    ST_CMP,
    ST_END
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic append;
    logic clear;
    logic search_start;
    logic div_start;
    logic emit_miss;
    logic round_init;
    logic probe_addr;
    logic probe_cmp;
    logic round_end;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic range_empty;
    logic div_busy;
    logic last_probe;
    logic hit;
  } stat_t;

endpackage

`default_nettype wire

FILE: sv/n_ary_sorted_search.sv
// Top level of the n-ary sorted search block.
// Append, clear and unknown items are handled in idle; busy stays low.
// A search runs rounds of P probes each; every round first splits the range with
// the bit-serial range divider (NW = clog2(TABLE_DEPTH+1) quotient bits), and each
// probe does a registered table read before its compare; the result strobes in the
// first cycle with busy low. Synchronous active-low reset empties the table
// (count to zero), sets the probe count to one and returns the controller to idle.
`default_nettype none

module n_ary_sorted_search
  import nass_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int MAX_PROBES  = 7
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [1:0]               in_kind,
  input  wire logic signed [WORD_W-1:0] in_value,
  output logic                          out_valid,
  output logic                          out_found,
  output logic [POS_W-1:0]              out_position,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_W-1:0]         cfg_data
);

  cmd_t  cmd;
  stat_t st;

  assign cfg_ready = 1'b1;

  nass_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_kind),
    .st      (st),
    .cmd     (cmd),
    .busy    (busy)
  );

  nass_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_PROBES  (MAX_PROBES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .st           (st),
    .in_value     (in_value),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_found    (out_found),
    .out_position (out_position)
  );

endmodule

`default_nettype wire

FILE: sv/nass_ram.sv
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module nass_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/nass_div.sv
// Restoring divider, one quotient bit per cycle; splits the range by probe count plus one.
`default_nettype none

module nass_div #(
  parameter int NW = 11,
  parameter int DW = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               busy,
  output logic [NW-1:0]      quot,
  output logic [DW-1:0]      rem
);

  localparam int CNW = $clog2(NW + 1);

  logic [NW-1:0]  dvd_r, dvd_nxt;
  logic [DW-1:0]  rem_r, rem_nxt;
  logic [DW-1:0]  dvs_r;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic [DW:0]    trial;
  logic [DW:0]    diff;
  logic           ge;

  // One shift-subtract step
  always_comb begin
    trial    = {rem_r, dvd_r[NW-1]};
    diff     = trial - {1'b0, dvs_r};
    ge       = (trial >= {1'b0, dvs_r});
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[NW-2:0], ge};
      rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
      cnt_nxt = cnt_r - CNW'(1);
      if (cnt_r == CNW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign busy = busy_r;
  assign quot = dvd_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

FILE: sv/nass_dp.sv
// Datapath: word table, range registers, probe position stepping and compare.
`default_nettype none

module nass_dp
  import nass_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int MAX_PROBES  = 7
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire cmd_t                     cmd,
  output stat_t                         st,
  input  wire logic signed [WORD_W-1:0] in_value,
  input  wire logic                     cfg_valid,
  input  wire logic [CFG_W-1:0]         cfg_data,
  output logic                          out_valid,
  output logic                          out_found,
  output logic [POS_W-1:0]              out_position
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int NW = CW;
  localparam int PW = $clog2(MAX_PROBES + 1);
  localparam int DW = $clog2(MAX_PROBES + 2);
  localparam int XW = $clog2(TABLE_DEPTH + MAX_PROBES + 2) + 1;
  localparam int EW = XW + POS_W;
  localparam logic signed [XW-1:0] ONE_X = XW'(1);

  // Configuration
  logic [CFG_W-1:0] probes_r;
  logic [PW-1:0]    p_act;
  logic [DW-1:0]    divisor;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probes_r <= CFG_W'(1);
    end else if (cfg_valid) begin
      probes_r <= cfg_data;
    end
  end

  // Zero acts as one, values over the maximum saturate
  always_comb begin
    if (probes_r == '0) begin
      p_act = PW'(1);
    end else if (int'(probes_r) > MAX_PROBES) begin
      p_act = PW'(MAX_PROBES);
    end else begin
      p_act = PW'(probes_r);
    end
  end

  assign divisor = DW'(p_act) + DW'(1);

  // Word count
  logic [CW-1:0] count_r;
  logic          room;

  assign room = (count_r < CW'(TABLE_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.clear) begin
      count_r <= '0;
    end else if (cmd.append && room) begin
      count_r <= count_r + CW'(1);
    end
  end

  // Search registers
  logic signed [WORD_W-1:0] key_r;
  logic signed [XW-1:0]     lo_r, hi_r, at_r, prev_probe_r, nlo_r, nhi_r, hit_pos_r;
  logic [NW-1:0]            q_r;
  logic [DW-1:0]            r_r;
  logic [PW-1:0]            idx_r;
  logic                     in_range_r;
  cmp_t                     prev_cmp_r;
  logic                     hit_r;

  // Range divider
  logic [NW-1:0] qn;
  logic [DW-1:0] rn;
  logic          div_busy;
  logic signed [XW-1:0] n_x;

  assign n_x = hi_r - lo_r + ONE_X;

  nass_div #(
    .NW (NW),
    .DW (DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (n_x[NW-1:0]),
    .divisor  (divisor),
    .busy     (div_busy),
    .quot     (qn),
    .rem      (rn)
  );

  // Probe position from the running quotient
  logic signed [XW-1:0] at_nxt;
  logic                 in_range_nxt;

  assign at_nxt       = lo_r + $signed(XW'(q_r)) + $signed(XW'(idx_r)) - ONE_X;
  assign in_range_nxt = (at_nxt <= hi_r);

  // Table RAM
  logic [WORD_W-1:0] rd_data;

  nass_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.append && room),
    .waddr (count_r[AW-1:0]),
    .wdata (in_value),
    .re    (cmd.probe_addr && in_range_nxt),
    .raddr (at_nxt[AW-1:0]),
    .rdata (rd_data)
  );

  // Probe compare against key
  cmp_t                 cmp_i;
  logic signed [XW-1:0] probe_i;
  logic [DW:0]          r_sum;
  logic                 r_wrap;

  always_comb begin
    if (!in_range_r) begin
      cmp_i = CMP_GREATER;
    end else if ($signed(rd_data) > key_r) begin
      cmp_i = CMP_GREATER;
    end else if ($signed(rd_data) < key_r) begin
      cmp_i = CMP_LESS;
    end else begin
      cmp_i = CMP_EQUAL;
    end
    probe_i = in_range_r ? at_r : hi_r + ONE_X;
    r_sum   = {1'b0, r_r} + {1'b0, rn};
    r_wrap  = (r_sum >= {1'b0, divisor});
  end

  // Search state updates
  always_ff @(posedge clk) begin
    if (cmd.search_start) begin
      key_r <= in_value;
      lo_r  <= '0;
      hi_r  <= $signed(XW'(count_r)) - ONE_X;
    end
    if (cmd.round_init) begin
      q_r          <= qn;
      r_r          <= rn;
      idx_r        <= PW'(1);
      prev_cmp_r   <= CMP_LESS;
      prev_probe_r <= lo_r - ONE_X;
      nlo_r        <= lo_r;
      nhi_r        <= hi_r;
      hit_r        <= 1'b0;
    end
    if (cmd.probe_addr) begin
      at_r       <= at_nxt;
      in_range_r <= in_range_nxt;
    end
    if (cmd.probe_cmp) begin
      if (cmp_i != prev_cmp_r) begin
        nlo_r <= prev_probe_r + ONE_X;
        nhi_r <= probe_i - ONE_X;
      end
      if (cmp_i == CMP_EQUAL) begin
        hit_r     <= 1'b1;
        hit_pos_r <= at_r;
      end
      prev_cmp_r   <= cmp_i;
      prev_probe_r <= probe_i;
      idx_r        <= idx_r + PW'(1);
      if (r_wrap) begin
        r_r <= DW'(r_sum - {1'b0, divisor});
        q_r <= q_r + qn + NW'(1);
      end else begin
        r_r <= r_sum[DW-1:0];
        q_r <= q_r + qn;
      end
    end
    // Narrow to the span where the compares change
    if (cmd.round_end && !hit_r) begin
      lo_r <= (prev_cmp_r != CMP_GREATER) ? prev_probe_r + ONE_X : nlo_r;
      hi_r <= nhi_r;
    end
  end

  // Result registers
  logic [EW-1:0] hit_ext;

  assign hit_ext = EW'(hit_pos_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit_miss || (cmd.round_end && hit_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_miss) begin
      out_found    <= 1'b0;
      out_position <= '0;
    end else if (cmd.round_end && hit_r) begin
      out_found    <= 1'b1;
      out_position <= hit_ext[POS_W-1:0];
    end
  end

  // Status to controller
  assign st.range_empty = (lo_r > hi_r);
  assign st.div_busy    = div_busy;
  assign st.last_probe  = (idx_r == p_act);
  assign st.hit         = hit_r;

endmodule

`default_nettype wire

FILE: sv/nass_ctrl.sv
// Controller: sequences search rounds, probe reads and result emission.
`default_nettype none

module nass_ctrl
  import nass_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [1:0]  in_kind,
  input  wire stat_t       st,
  output cmd_t             cmd,
  output logic             busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (in_kind)
            KIND_APPEND: cmd.append = 1'b1;
            KIND_CLEAR:  cmd.clear  = 1'b1;
            KIND_SEARCH: begin
              cmd.search_start = 1'b1;
              state_nxt        = ST_ROUND;
            end
            default: ;
          endcase
        end
      end
      ST_ROUND: begin
        if (st.range_empty) begin
          cmd.emit_miss = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!st.div_busy) begin
          cmd.round_init = 1'b1;
          state_nxt      = ST_ADDR;
        end
      end
      ST_ADDR: begin
        cmd.probe_addr = 1'b1;
        state_nxt      = ST_CMP;
      end
      ST_CMP: begin
        cmd.probe_cmp = 1'b1;
        state_nxt     = st.last_probe ? ST_END : ST_ADDR;
      end
      ST_END: begin
        cmd.round_end = 1'b1;
        state_nxt     = st.hit ? ST_IDLE : ST_ROUND;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

`default_nettype wire

FILE: sv/nass_chk.sv
// Port-level checker for the n-ary sorted search block, with its bind.
`default_nettype none

module nass_chk
  import nass_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             start,
  input wire logic             busy,
  input wire logic [1:0]       in_kind,
  input wire logic             out_valid,
  input wire logic             out_found,
  input wire logic [POS_W-1:0] out_position
);

  // A result only follows the end of a search
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a preceding search");

  // Every finished search gives a result
  a_busy_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_valid)
    else $error("search ended without a result");

  // A miss reports position zero
  a_miss_position: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_position == '0)
    else $error("miss with nonzero position");

  // A search item starts work at once
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_kind == KIND_SEARCH |=> busy)
    else $error("search item did not start");

  // Other items finish in their own cycle and give no result
  a_other_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_kind != KIND_SEARCH |=> !busy && !out_valid)
    else $error("non-search item caused work or a result");

endmodule

bind n_ary_sorted_search nass_chk u_nass_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_kind      (in_kind),
  .out_valid    (out_valid),
  .out_found    (out_found),
  .out_position (out_position)
);

`default_nettype wire
